@@ rtl/core/pnfef_pkg.sv @@
// ----------------------------------------------------------------------------
// Petri net package
// Shared types and command codes for the first-enabled firing block.
// ----------------------------------------------------------------------------
package pnfef_pkg;

   typedef enum logic [1:0] {
      CMD_SET_MARK = 2'd0,
      CMD_SET_ARC  = 2'd1,
      CMD_FIRE     = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   localparam int TSEL_W  = 4;
   localparam int PSEL_W  = 4;
   localparam int CNT_W   = 16;
   localparam int WGT_W   = 8;

   // Controller to datapath.
   typedef struct packed {
      logic set_mark;    // write marking entry from request
      logic set_arc;     // write arc pair from request
      logic scan_start;  // begin a fire scan at transition 0
      logic scan_next;   // advance the scan by one transition
      logic do_fire;     // apply current transition to the marking
      logic load_read;   // capture a read result
      logic load_dead;   // capture a dead result
   } ctrl_type;

   // Datapath to controller.
   typedef struct packed {
      logic enabled;     // current transition is enabled
      logic last;        // current transition is the last one
   } stat_type;

endpackage

@@ rtl/core/pnfef_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface pnfef_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/pnfef_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pnfef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/pnfef_ctrl.sv @@
// ----------------------------------------------------------------------------
// Petri net controller
// Sequences loads, reads and the transition scan of a fire step.
// ----------------------------------------------------------------------------
module pnfef_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  pnfef_pkg::cmd_type  req_cmd,
   output logic                req_ready,
   input  logic                rsp_busy,
   output logic                rsp_load,
   output pnfef_pkg::ctrl_type ctrl,
   input  pnfef_pkg::stat_type stat
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WAIT = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept    = req_valid && req_ready;
   // No request is taken while a result waits in the result register.
   assign req_ready = (state_ff == ST_IDLE) && !rsp_busy;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  pnfef_pkg::CMD_SET_MARK: ctrl.set_mark = 1'b1;
                  pnfef_pkg::CMD_SET_ARC:  ctrl.set_arc  = 1'b1;
                  pnfef_pkg::CMD_FIRE: begin
                     ctrl.scan_start = 1'b1;
                     state_in        = ST_WAIT;
                  end
                  pnfef_pkg::CMD_READ: begin
                     ctrl.load_read = 1'b1;
                     rsp_load       = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT: state_in = ST_EVAL; // RAM read latency
         ST_EVAL: begin
            if (stat.enabled) begin
               ctrl.do_fire = 1'b1;
               rsp_load     = 1'b1;
               state_in     = ST_IDLE;
            end else if (stat.last) begin
               ctrl.load_dead = 1'b1;
               rsp_load       = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               ctrl.scan_next = 1'b1;
               state_in       = ST_WAIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/core/pnfef_dp.sv @@
// ----------------------------------------------------------------------------
// Petri net datapath
// Marking registers, arc memories per place and the enable/fire logic.
// ----------------------------------------------------------------------------
module pnfef_dp #(
   parameter int NUM_PLACES      = 16,
   parameter int NUM_TRANSITIONS = 16,
   parameter int COUNT_WIDTH     = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pnfef_pkg::TSEL_W-1:0] req_tsel,
   input  logic [pnfef_pkg::PSEL_W-1:0] req_psel,
   input  logic [pnfef_pkg::CNT_W-1:0]  req_count,
   input  logic [pnfef_pkg::WGT_W-1:0]  req_take,
   input  logic [pnfef_pkg::WGT_W-1:0]  req_give,
   input  pnfef_pkg::ctrl_type          ctrl,
   output pnfef_pkg::stat_type          stat,
   output logic [pnfef_pkg::TSEL_W-1:0] res_fired,
   output logic                         res_dead,
   output logic [pnfef_pkg::CNT_W-1:0]  res_tokens,
   output logic                         res_overflow
);
   localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
   localparam int PW = (NUM_PLACES > 1) ? $clog2(NUM_PLACES) : 1;
   localparam int SW = ((COUNT_WIDTH > pnfef_pkg::WGT_W) ? COUNT_WIDTH
                                                         : pnfef_pkg::WGT_W) + 2;
   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] mark_ff [NUM_PLACES];
   logic [TW-1:0]          scan_ff;
   // Transitions never written read as zero arcs.
   logic [NUM_TRANSITIONS-1:0] tvalid_ff [NUM_PLACES];
   logic [NUM_PLACES-1:0]      ok, sat;
   logic [COUNT_WIDTH-1:0]     nxt [NUM_PLACES];
   logic [pnfef_pkg::WGT_W-1:0] tk_raw [NUM_PLACES];
   logic [pnfef_pkg::WGT_W-1:0] gv_raw [NUM_PLACES];
   logic                       in_t, in_p;
   logic [TW-1:0]              rd_t;
   // Valid bit of the arc entry being read, registered alongside the RAM data.
   logic [NUM_PLACES-1:0]      rv_ff;

   assign in_t = 32'(req_tsel) < NUM_TRANSITIONS;
   assign in_p = 32'(req_psel) < NUM_PLACES;
   assign rd_t = ctrl.scan_start ? '0 : (ctrl.scan_next ? scan_ff + 1'b1 : scan_ff);

   for (genvar p = 0; p < NUM_PLACES; p++) begin : g_place
      logic [pnfef_pkg::WGT_W-1:0] tk, gv;
      logic [SW-1:0]               sum;
      logic                        we;

      assign we = ctrl.set_arc && in_t && in_p && (32'(req_psel) == p);

      pnfef_ram #(.WIDTH(2*pnfef_pkg::WGT_W), .DEPTH(2**TW)) u_arc (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (TW'(req_tsel)),
         .wr_data ({req_take, req_give}),
         .rd_addr (rd_t),
         .rd_data ({tk_raw[p], gv_raw[p]})
      );

      assign tk  = rv_ff[p] ? tk_raw[p] : '0;
      assign gv  = rv_ff[p] ? gv_raw[p] : '0;
      assign ok[p]  = SW'(mark_ff[p]) >= SW'(tk);
      assign sum    = SW'(mark_ff[p]) - SW'(tk) + SW'(gv);
      assign sat[p] = sum > SW'(CMAX);
      assign nxt[p] = sat[p] ? CMAX : sum[COUNT_WIDTH-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            tvalid_ff[p] <= '0;
            mark_ff[p]   <= '0;
         end else begin
            if (we) tvalid_ff[p][TW'(req_tsel)] <= 1'b1;
            if (ctrl.set_mark && in_p && (32'(req_psel) == p)) begin
               mark_ff[p] <= COUNT_WIDTH'(req_count);
            end else if (ctrl.do_fire) begin
               mark_ff[p] <= nxt[p];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PLACES; p++) rv_ff[p] <= tvalid_ff[p][rd_t];
   end

   always_ff @(posedge clock) begin
      if (reset) scan_ff <= '0;
      else if (ctrl.scan_start || ctrl.scan_next) scan_ff <= rd_t;
   end

   assign stat.enabled = &ok;
   assign stat.last    = 32'(scan_ff) == NUM_TRANSITIONS - 1;

   always_ff @(posedge clock) begin
      if (ctrl.load_read) begin
         res_fired    <= '0;
         res_dead     <= 1'b0;
         res_overflow <= 1'b0;
         res_tokens   <= in_p ? pnfef_pkg::CNT_W'(mark_ff[PW'(req_psel)]) : '0;
      end else if (ctrl.do_fire) begin
         res_fired    <= pnfef_pkg::TSEL_W'(scan_ff);
         res_dead     <= 1'b0;
         res_overflow <= |sat;
         res_tokens   <= '0;
      end else if (ctrl.load_dead) begin
         res_fired    <= '0;
         res_dead     <= 1'b1;
         res_overflow <= 1'b0;
         res_tokens   <= '0;
      end
   end
endmodule

@@ rtl/core/petri_net_first_enabled_fire.sv @@
// ----------------------------------------------------------------------------
// Petri net token game, first-enabled firing
//
//   channel  direction  content
//   req      in         cmd, transition_sel, place_sel, token_count, weights
//   rsp      out        fired_transition, dead, place_tokens, overflow
//
// Loads are written when accepted; a read goes to the result register.
// A fire step scans the transitions in order, each through a wait state
// for the registered read of the per-place arc RAMs and an evaluate state.
// Reset clears the marking and arc valid bits at once; no clearing pass.
// While a result waits for transfer, every request is held off.
// ----------------------------------------------------------------------------
module petri_net_first_enabled_fire #(
   parameter int NUM_PLACES      = 16,
   parameter int NUM_TRANSITIONS = 16,
   parameter int COUNT_WIDTH     = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic [pnfef_pkg::TSEL_W-1:0] req_transition_sel,
   input  logic [pnfef_pkg::PSEL_W-1:0] req_place_sel,
   input  logic [pnfef_pkg::CNT_W-1:0]  req_token_count,
   input  logic [pnfef_pkg::WGT_W-1:0]  req_take_weight,
   input  logic [pnfef_pkg::WGT_W-1:0]  req_give_weight,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pnfef_pkg::TSEL_W-1:0] rsp_fired_transition,
   output logic                         rsp_dead,
   output logic [pnfef_pkg::CNT_W-1:0]  rsp_place_tokens,
   output logic                         rsp_overflow
);
   pnfef_pkg::ctrl_type ctrl;
   pnfef_pkg::stat_type stat;
   logic                rsp_load;
   logic                rsp_valid_ff;

   pnfef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (pnfef_pkg::cmd_type'(req_cmd)),
      .req_ready (req_ready),
      .rsp_busy  (rsp_valid_ff),
      .rsp_load  (rsp_load),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   pnfef_dp #(
      .NUM_PLACES      (NUM_PLACES),
      .NUM_TRANSITIONS (NUM_TRANSITIONS),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_tsel     (req_transition_sel),
      .req_psel     (req_place_sel),
      .req_count    (req_token_count),
      .req_take     (req_take_weight),
      .req_give     (req_give_weight),
      .ctrl         (ctrl),
      .stat         (stat),
      .res_fired    (rsp_fired_transition),
      .res_dead     (rsp_dead),
      .res_tokens   (rsp_place_tokens),
      .res_overflow (rsp_overflow)
   );

   // The result register holds until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("request taken while result pending");
   a_fire_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.do_fire && ctrl.load_dead)) else $error("fire and dead together");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff) else $error("result overwritten");
`endif
endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Petri net first-enabled firing testbench
// Drives load, fire and read items into the block over a valid/ready channel
// and checks every result against a built-in model of the token game.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NET_PLACES      = 16;
   localparam int NET_TRANSITIONS = 16;
   localparam int COUNT_MAX       = 65535;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 40;

   // One request transfer: a load, a fire step or a read.
   typedef struct packed {
      pnfef_pkg::cmd_type                cmd;
      logic [pnfef_pkg::TSEL_W-1:0]      transition_sel;
      logic [pnfef_pkg::PSEL_W-1:0]      place_sel;
      logic [pnfef_pkg::CNT_W-1:0]       token_count;
      logic [pnfef_pkg::WGT_W-1:0]       take_weight;
      logic [pnfef_pkg::WGT_W-1:0]       give_weight;
   } net_cmd_type;

   // One result transfer, from a fire step or a read.
   typedef struct packed {
      logic [pnfef_pkg::TSEL_W-1:0]  fired_transition;
      logic                          dead;
      logic [pnfef_pkg::CNT_W-1:0]   place_tokens;
      logic                          overflow;
   } net_result_type;

   logic clock;
   logic reset;

   pnfef_if #(.payload_type(net_cmd_type))    req_ch ();
   pnfef_if #(.payload_type(net_result_type)) rsp_ch ();

   petri_net_first_enabled_fire u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_ch.valid),
      .req_ready            (req_ch.ready),
      .req_cmd              (req_ch.payload.cmd),
      .req_transition_sel   (req_ch.payload.transition_sel),
      .req_place_sel        (req_ch.payload.place_sel),
      .req_token_count      (req_ch.payload.token_count),
      .req_take_weight      (req_ch.payload.take_weight),
      .req_give_weight      (req_ch.payload.give_weight),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_fired_transition (rsp_ch.payload.fired_transition),
      .rsp_dead             (rsp_ch.payload.dead),
      .rsp_place_tokens     (rsp_ch.payload.place_tokens),
      .rsp_overflow         (rsp_ch.payload.overflow)
   );

   // Clock with a period of 10 time units.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the net kept by the testbench. It is updated at the moment a
   // request transfer happens, so the results it yields stay in order.
   logic [pnfef_pkg::CNT_W-1:0] token_mirror [NET_PLACES];
   logic [pnfef_pkg::WGT_W-1:0] take_mirror  [NET_TRANSITIONS][NET_PLACES];
   logic [pnfef_pkg::WGT_W-1:0] give_mirror  [NET_TRANSITIONS][NET_PLACES];

   net_result_type pending_results[$];
   int          error_count;
   int          idle_cycles;
   bit          sender_idles;   // random gaps between request transfers
   bit          receiver_idles; // random stalls on the result side
   int          hold_left;      // cycles the receiver still holds off

   // Plays one item through the mirrored net. Returns 1 when the item yields
   // a result. A transition is enabled when every place holds at least its
   // take weight, so a transition with no take weights is always enabled.
   function automatic bit play_token_game(input net_cmd_type item,
                                          output net_result_type res);
      int  total;
      bit  ready_to_fire;
      res = '0;
      case (item.cmd)
         pnfef_pkg::CMD_SET_MARK: begin
            token_mirror[item.place_sel] = item.token_count;
            return 1'b0;
         end
         pnfef_pkg::CMD_SET_ARC: begin
            take_mirror[item.transition_sel][item.place_sel] = item.take_weight;
            give_mirror[item.transition_sel][item.place_sel] = item.give_weight;
            return 1'b0;
         end
         pnfef_pkg::CMD_FIRE: begin
            for (int t = 0; t < NET_TRANSITIONS; t++) begin
               ready_to_fire = 1'b1;
               for (int p = 0; p < NET_PLACES; p++)
                  if (token_mirror[p] < take_mirror[t][p]) ready_to_fire = 1'b0;
               if (ready_to_fire) begin
                  for (int p = 0; p < NET_PLACES; p++) begin
                     total = int'(token_mirror[p]) - int'(take_mirror[t][p])
                             + int'(give_mirror[t][p]);
                     if (total > COUNT_MAX) begin
                        total = COUNT_MAX;
                        res.overflow = 1'b1;
                     end
                     token_mirror[p] = total[pnfef_pkg::CNT_W-1:0];
                  end
                  res.fired_transition = t[pnfef_pkg::TSEL_W-1:0];
                  return 1'b1;
               end
            end
            // Nothing enabled: a dead step leaves the marking alone.
            res.dead = 1'b1;
            return 1'b1;
         end
         default: begin
            res.place_tokens = token_mirror[item.place_sel];
            return 1'b1;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // Sender gap: mostly none or short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends one item and records the result it should cause. Valid stays high
   // between back-to-back items, so it is never lowered and raised in one step.
   task automatic send_item(input net_cmd_type item);
      net_result_type res;
      int          gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      if (play_token_game(item, res)) pending_results = {pending_results, res};
   endtask

   task automatic send_mark(input int place, input int count);
      net_cmd_type item;
      item = '0;
      item.cmd = pnfef_pkg::CMD_SET_MARK;
      item.place_sel = place[pnfef_pkg::PSEL_W-1:0];
      item.token_count = count[pnfef_pkg::CNT_W-1:0];
      send_item(item);
   endtask

   task automatic send_arc(input int trans, input int place, input int take, input int give);
      net_cmd_type item;
      item = '0;
      item.cmd = pnfef_pkg::CMD_SET_ARC;
      item.transition_sel = trans[pnfef_pkg::TSEL_W-1:0];
      item.place_sel = place[pnfef_pkg::PSEL_W-1:0];
      item.take_weight = take[pnfef_pkg::WGT_W-1:0];
      item.give_weight = give[pnfef_pkg::WGT_W-1:0];
      send_item(item);
   endtask

   task automatic send_fire();
      net_cmd_type item;
      item = '0;
      item.cmd = pnfef_pkg::CMD_FIRE;
      send_item(item);
   endtask

   task automatic send_read(input int place);
      net_cmd_type item;
      item = '0;
      item.cmd = pnfef_pkg::CMD_READ;
      item.place_sel = place[pnfef_pkg::PSEL_W-1:0];
      send_item(item);
   endtask

   // Result checker: every result transfer is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      net_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected results", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.payload.fired_transition !== want.fired_transition)
               report_mismatch("fired_transition", rsp_ch.payload.fired_transition,
                               want.fired_transition);
            if (rsp_ch.payload.dead !== want.dead)
               report_mismatch("dead", rsp_ch.payload.dead, want.dead);
            if (rsp_ch.payload.place_tokens !== want.place_tokens)
               report_mismatch("place_tokens", rsp_ch.payload.place_tokens,
                               want.place_tokens);
            if (rsp_ch.payload.overflow !== want.overflow)
               report_mismatch("overflow", rsp_ch.payload.overflow, want.overflow);
         end
      end
   end

   // Receiver: a forced hold-off wins, otherwise random short stalls and an
   // occasional long one while stalls are turned on.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (!receiver_idles) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            hold_left = $urandom_range(10, 40);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (roll >= 27);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // After reset the net is empty: every place reads zero, and since no
   // transition has take weights, transition 0 fires.
   task automatic test_reset_state();
      send_read(0);
      send_read(15);
      send_fire();
   endtask

   // Extreme counts are written and read back.
   task automatic test_marking_loads();
      send_mark(15, COUNT_MAX);
      send_read(15);
      send_mark(0, 16'h5AA5);
      send_read(0);
      send_mark(15, 0);
   endtask

   // Saturation on firing, then a blocked transition 0 lets transition 1 fire.
   task automatic test_fire_and_overflow();
      send_mark(0, COUNT_MAX);
      send_arc(0, 0, 0, 255);
      send_fire();
      send_read(0);
      send_arc(15, 15, 255, 255);
      send_arc(0, 0, 1, 0);
      send_mark(0, 0);
      send_fire();
   endtask

   // Every transition wants 255 tokens from place 5, which is empty: dead.
   // Place 5 then gets exactly enough and transition 0 fires again.
   task automatic test_dead_step();
      for (int t = 0; t < NET_TRANSITIONS; t++) send_arc(t, 5, 255, t);
      send_fire();
      send_mark(0, 1);
      send_mark(5, 255);
      send_fire();
      send_read(5);
      send_fire();
   endtask

   // The receiver holds off for a long stretch while reads and fire steps
   // keep coming, so the block fills up and stalls its input.
   task automatic test_backpressure();
      hold_left = 300;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 0) send_fire();
         else send_read($urandom_range(0, NET_PLACES - 1));
      end
   endtask

   // Random nets: each episode gives every transition a small take weight on
   // some place, sprinkles more arcs and markings, then fires and reads.
   task automatic test_random_nets(input int episodes);
      int roll;
      for (int e = 0; e < episodes; e++) begin
         sender_idles   = (e % 7 != 3);
         receiver_idles = (e % 5 != 2);
         for (int t = 0; t < NET_TRANSITIONS; t++)
            send_arc(t, $urandom_range(0, NET_PLACES - 1), $urandom_range(1, 3),
                     $urandom_range(0, 4));
         for (int i = 0; i < 8; i++) begin
            roll = $urandom_range(0, 9);
            send_arc($urandom_range(0, NET_TRANSITIONS - 1), $urandom_range(0, NET_PLACES - 1),
                     roll == 0 ? $urandom_range(0, 255) : $urandom_range(0, 2),
                     roll == 1 ? $urandom_range(0, 255) : $urandom_range(0, 5));
         end
         for (int i = 0; i < 6; i++) begin
            roll = $urandom_range(0, 9);
            send_mark($urandom_range(0, NET_PLACES - 1),
                      roll == 0 ? $urandom_range(0, COUNT_MAX) :
                      roll == 1 ? $urandom_range(COUNT_MAX - 8, COUNT_MAX) :
                      $urandom_range(0, 6));
         end
         for (int i = 0; i < 16; i++) begin
            if ($urandom_range(0, 2) == 0) send_read($urandom_range(0, NET_PLACES - 1));
            else send_fire();
         end
      end
   endtask

   // Fully random items with every field at random.
   task automatic test_noise(input int count);
      net_cmd_type item;
      for (int i = 0; i < count; i++) begin
         item.cmd            = pnfef_pkg::cmd_type'(2'($urandom_range(0, 3)));
         item.transition_sel = pnfef_pkg::TSEL_W'($urandom_range(0, NET_TRANSITIONS - 1));
         item.place_sel      = pnfef_pkg::PSEL_W'($urandom_range(0, NET_PLACES - 1));
         item.token_count    = pnfef_pkg::CNT_W'($urandom_range(0, COUNT_MAX));
         item.take_weight    = pnfef_pkg::WGT_W'($urandom_range(0, 255));
         item.give_weight    = pnfef_pkg::WGT_W'($urandom_range(0, 255));
         send_item(item);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      error_count    = 0;
      idle_cycles    = 0;
      hold_left      = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      for (int p = 0; p < NET_PLACES; p++) begin
         token_mirror[p] = '0;
         for (int t = 0; t < NET_TRANSITIONS; t++) begin
            take_mirror[t][p] = '0;
            give_mirror[t][p] = '0;
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_marking_loads();
      test_fire_and_overflow();
      test_dead_step();
      test_backpressure();
      test_random_nets(37);
      test_noise(120);

      // The last item was taken at this edge; withdraw it at once.
      req_ch.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/pnfef_pkg.sv
rtl/core/pnfef_if.sv
rtl/core/pnfef_ram.sv
rtl/core/pnfef_ctrl.sv
rtl/core/pnfef_dp.sv
rtl/core/petri_net_first_enabled_fire.sv
dv/tb_top.sv
